// ----- rtl/bfa_pkg.sv -----
// Shared constants, codes and control types of the bitmap frame allocator.
package bfa_pkg;

    localparam int FRAMES         = 4096;
    localparam int PAGE_SHIFT     = 12;
    localparam int ADDR_W         = 24;
    localparam int CNT_W          = 13;
    localparam int FRAME_W        = $clog2(FRAMES);
    localparam int BYTE_BITS      = 8;
    localparam int BYTES_PER_WORD = 8;
    localparam int BSEL_W         = $clog2(BYTES_PER_WORD);
    localparam int BIT_W          = $clog2(BYTE_BITS);
    localparam int WORD_BITS      = BYTES_PER_WORD * BYTE_BITS;
    localparam int WBIT_W         = $clog2(WORD_BITS);
    localparam int WORDS          = FRAMES / WORD_BITS;
    localparam int WADDR_W        = $clog2(WORDS);
    localparam int WCNT_W         = WADDR_W + 1;
    localparam int MAP_BYTES      = FRAMES / BYTE_BITS;
    localparam int CFG_W          = 10;
    localparam int ST_W           = 2;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 56;
    localparam int OUT_PAD_W      = OUT_TDATA_W - ADDR_W - 2 * CNT_W;
    localparam int PADDR_W        = 3;
    localparam int APB_DW         = 32;

    localparam logic [CFG_W-1:0] BITMAP_BYTES_RST = CFG_W'(512);

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_BITMAP_BYTES = 1'b0;

    typedef struct packed {
        logic            load;
        logic            rd;
        logic            adv;
        logic            wr;
        logic            set_res;
        logic            res_hit;
        logic [ST_W-1:0] res_status;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic range_err;
        logic scan_empty;
        logic found;
        logic more;
    } t_dp_stat;

endpackage

// ----- rtl/bitmap_frame_allocator.sv -----
// Top level of the first-fit bitmap frame allocator with its configuration register.
// Sequence: a request is loaded, a map word is read (SEL), checked and written (CHK), and the
// result is registered (OUT); an allocate reads n 64-bit map words (1 to 64; none for an empty search).
// Throughput: one request at a time; the next is taken in the cycle after the result is
// loaded, so the word scan of the map memory (one word per cycle) and output back-pressure set the rate.
// Reset: all frames read as used through per-word valid flags, counters clear to zero.
module bitmap_frame_allocator
    import bfa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // address[23:0]
    input  logic                   i_s_tuser,   // command[0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // frame_address[23:0], free_count[36:24],
                                                // used_count[49:37], zero pad
    output logic [ST_W-1:0]        o_m_tuser,   // status[1:0]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic [CFG_W-1:0]  r_bitmap_bytes;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [ADDR_W-1:0] w_frame_address;
    logic [CNT_W-1:0]  w_free_count;
    logic [CNT_W-1:0]  w_used_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitmap_bytes <= BITMAP_BYTES_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BITMAP_BYTES) begin
            r_bitmap_bytes <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BITMAP_BYTES) ? APB_DW'(r_bitmap_bytes) : '0;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bfa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_bitmap_bytes  (r_bitmap_bytes),
        .i_command       (i_s_tuser),
        .i_address       (i_s_tdata[ADDR_W-1:0]),
        .o_stat          (w_stat),
        .o_frame_address (w_frame_address),
        .o_status        (o_m_tuser),
        .o_free_count    (w_free_count),
        .o_used_count    (w_used_count)
    );

    assign o_m_tdata = {{OUT_PAD_W{1'b0}}, w_used_count, w_free_count, w_frame_address};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (w_frame_address == '0))
        else $error("failed request returned a frame address");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_free_count <= CNT_W'(FRAMES) && w_used_count <= CNT_W'(FRAMES)))
        else $error("frame counter past limit");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_NONE || o_m_tuser == ST_RANGE))
        else $error("undefined status code");

endmodule

// ----- rtl/bfa_dp.sv -----
// Datapath: bitmap word memory, first-zero search, frame counters and result register.
module bfa_dp
    import bfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [CFG_W-1:0]   i_bitmap_bytes,
    input  logic               i_command,
    input  logic [ADDR_W-1:0]  i_address,
    output t_dp_stat           o_stat,
    output logic [ADDR_W-1:0]  o_frame_address,
    output logic [ST_W-1:0]    o_status,
    output logic [CNT_W-1:0]   o_free_count,
    output logic [CNT_W-1:0]   o_used_count
);

    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    logic                 r_is_free;
    logic                 r_range;
    logic [FRAME_W-1:0]   r_frame;
    logic [WCNT_W-1:0]    r_word;
    logic [WCNT_W-1:0]    r_limit_words;
    logic [CFG_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_free_cnt;
    logic [CNT_W-1:0]     r_used_cnt;
    logic [ADDR_W-1:0]    r_res_addr;
    logic [ST_W-1:0]      r_res_status;
    logic [ADDR_W-1:0]    r_o_addr;
    logic [ST_W-1:0]      r_o_status;
    logic [CNT_W-1:0]     r_o_free;
    logic [CNT_W-1:0]     r_o_used;

    logic [CFG_W-1:0]     n_limit;
    logic [CFG_W:0]       w_limit_sum;
    logic [WCNT_W-1:0]    w_word_next;
    logic [WADDR_W-1:0]   w_rd_addr;
    logic [WADDR_W-1:0]   w_free_word;
    logic [WORD_BITS-1:0] w_eff;
    logic [WORD_BITS-1:0] w_masked;
    logic [BYTE_BITS-1:0] w_sel_byte_val;
    logic [BSEL_W-1:0]    w_sel_byte;
    logic [BIT_W-1:0]     w_sel_bit;
    logic                 w_found;
    logic [FRAME_W-1:0]   w_hit_frame;
    logic [WORD_BITS-1:0] w_wr_data;
    logic [WADDR_W-1:0]   w_wr_addr;
    logic [CFG_W-1:0]     w_byte_idx;

    assign w_word_next = r_word + WCNT_W'(1);
    assign w_free_word = r_frame[FRAME_W-1 -: WADDR_W];
    assign n_limit     = (i_bitmap_bytes > CFG_W'(MAP_BYTES)) ? CFG_W'(MAP_BYTES)
                                                              : i_bitmap_bytes;
    assign w_limit_sum = {1'b0, n_limit} + (CFG_W + 1)'(BYTES_PER_WORD - 1);

    always_comb begin
        if (r_is_free) begin
            w_rd_addr = w_free_word;
        end else if (i_cmd.adv) begin
            w_rd_addr = w_word_next[WADDR_W-1:0];
        end else begin
            w_rd_addr = r_word[WADDR_W-1:0];
        end
    end

    assign w_eff = r_rd_vld ? r_rd_data : '1;

    // Mask bytes past the search limit as full.
    always_comb begin
        for (int b = 0; b < BYTES_PER_WORD; b++) begin
            w_byte_idx = CFG_W'({r_word[WADDR_W-1:0], BSEL_W'(b)});
            w_masked[b*BYTE_BITS +: BYTE_BITS] = w_eff[b*BYTE_BITS +: BYTE_BITS]
                | {BYTE_BITS{(w_byte_idx >= r_limit)}};
        end
    end

    always_comb begin
        w_found    = 1'b0;
        w_sel_byte = '0;
        for (int b = BYTES_PER_WORD - 1; b >= 0; b--) begin
            if (w_masked[b*BYTE_BITS +: BYTE_BITS] != '1) begin
                w_found    = 1'b1;
                w_sel_byte = BSEL_W'(b);
            end
        end
    end

    assign w_sel_byte_val = w_masked[w_sel_byte*BYTE_BITS +: BYTE_BITS];

    always_comb begin
        w_sel_bit = '0;
        for (int k = BYTE_BITS - 1; k >= 0; k--) begin
            if (!w_sel_byte_val[k]) begin
                w_sel_bit = BIT_W'(k);
            end
        end
    end

    assign w_hit_frame = {r_word[WADDR_W-1:0], w_sel_byte, w_sel_bit};

    always_comb begin
        if (r_is_free) begin
            w_wr_addr = w_free_word;
            w_wr_data = w_eff & ~(WORD_BITS'(1) << r_frame[WBIT_W-1:0]);
        end else begin
            w_wr_addr = r_word[WADDR_W-1:0];
            w_wr_data = w_eff | (WORD_BITS'(1) << {w_sel_byte, w_sel_bit});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
        if (i_cmd.wr) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_free_cnt <= '0;
            r_used_cnt <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_rd_vld <= r_valid[w_rd_addr];
            end
            if (i_cmd.wr) begin
                r_valid[w_wr_addr] <= 1'b1;
                if (r_is_free) begin
                    if (r_free_cnt < CNT_W'(FRAMES)) r_free_cnt <= r_free_cnt + CNT_W'(1);
                    if (r_used_cnt != '0)            r_used_cnt <= r_used_cnt - CNT_W'(1);
                end else begin
                    if (r_free_cnt != '0)            r_free_cnt <= r_free_cnt - CNT_W'(1);
                    if (r_used_cnt < CNT_W'(FRAMES)) r_used_cnt <= r_used_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_free     <= (i_command == CMD_FREE);
            r_range       <= ((i_address >> PAGE_SHIFT) >= ADDR_W'(FRAMES));
            r_frame       <= i_address[PAGE_SHIFT +: FRAME_W];
            r_word        <= '0;
            r_limit       <= n_limit;
            r_limit_words <= WCNT_W'(w_limit_sum >> BSEL_W);
        end else if (i_cmd.adv) begin
            r_word <= w_word_next;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_addr   <= i_cmd.res_hit ? ADDR_W'({w_hit_frame, {PAGE_SHIFT{1'b0}}}) : '0;
        end
        if (i_cmd.out_load) begin
            r_o_addr   <= r_res_addr;
            r_o_status <= r_res_status;
            r_o_free   <= r_free_cnt;
            r_o_used   <= r_used_cnt;
        end
    end

    assign o_stat.is_free    = r_is_free;
    assign o_stat.range_err  = r_range;
    assign o_stat.scan_empty = (r_limit_words == '0);
    assign o_stat.found      = w_found;
    assign o_stat.more       = (w_word_next < r_limit_words);

    assign o_frame_address = r_o_addr;
    assign o_status        = r_o_status;
    assign o_free_count    = r_o_free;
    assign o_used_count    = r_o_used;

endmodule

// ----- rtl/bfa_ctrl.sv -----
// Controller: request sequencing state machine and output valid flag.
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEL;
                end
            end
            S_SEL: begin
                if (i_stat.is_free && i_stat.range_err) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_RANGE;
                    n_state          = S_OUT;
                end else if (!i_stat.is_free && i_stat.scan_empty) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NONE;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.is_free) begin
                    o_cmd.wr         = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_OUT;
                end else if (i_stat.found) begin
                    o_cmd.wr         = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_hit    = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_OUT;
                end else if (i_stat.more) begin
                    o_cmd.adv = 1'b1;
                    o_cmd.rd  = 1'b1;
                end else begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NONE;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
